// File: hw/rtl/lstk_pkg.sv
// Shared types and constants for the LIFO stack.
package lstk_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 8;
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] push_byte;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]  read_byte;
        logic               success;
        logic               is_empty;
        logic               is_full;
        logic [COUNT_W-1:0] entry_count;
    } t_rsp;

endpackage

// File: hw/rtl/lstk_if.sv
// Valid/ready channel interfaces for stack requests and responses.
interface lstk_req_if;
    logic            valid;
    logic            ready;
    lstk_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lstk_rsp_if;
    logic            valid;
    logic            ready;
    lstk_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/lstk_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module lstk_ram #(
    parameter int WIDTH = lstk_pkg::DATA_W,
    parameter int DEPTH = lstk_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lifo_stack.sv
// LIFO stack of bytes: push, pop and peek requests, one response per request.
// An accepted request moves to ST_EXEC, where it executes and its response is registered;
// execution waits while an earlier response is still held. No new request is taken until
// ST_IDLE again; the registered RAM read of the top entry is issued on accept for ST_EXEC.
// Reset: synchronous, active low; clears the fill level (stack empty) and the control state.
// Stack RAM contents are not cleared; only entries below the fill level are read.
module lifo_stack #(
    parameter int DEPTH = lstk_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lstk_req_if.sink    i_req,
    lstk_rsp_if.source  o_rsp
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    lstk_pkg::t_req      r_req;
    lstk_pkg::t_rsp      r_rsp, n_rsp;
    logic                r_out_valid, n_out_valid;

    logic                accept;
    logic                done;
    logic                can_push;
    logic                can_read;
    logic                is_push;
    logic                is_read;
    logic                ok;
    logic                ram_we;
    logic                ram_re;
    logic [FILL_W-1:0]   fill_m1;
    logic [lstk_pkg::DATA_W-1:0] ram_rdata;
    logic [FILL_W+lstk_pkg::COUNT_W-1:0] count_ext;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign done        = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    assign can_push = (r_fill != FILL_W'(DEPTH));
    assign can_read = (r_fill != '0);
    assign fill_m1  = r_fill - FILL_W'(1);

    assign is_push = (r_req.opcode == lstk_pkg::OP_PUSH);
    assign is_read = (r_req.opcode == lstk_pkg::OP_POP) ||
                     (r_req.opcode == lstk_pkg::OP_PEEK);
    assign ok      = (is_push && can_push) || (is_read && can_read);

    assign ram_re = accept && can_read &&
                    ((i_req.data.opcode == lstk_pkg::OP_POP) ||
                     (i_req.data.opcode == lstk_pkg::OP_PEEK));
    assign ram_we = done && is_push && can_push;

    lstk_ram #(
        .WIDTH (lstk_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (r_req.push_byte),
        .i_re    (ram_re),
        .i_raddr (fill_m1[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    if (is_push && can_push) begin
                        n_fill = r_fill + FILL_W'(1);
                    end else if ((r_req.opcode == lstk_pkg::OP_POP) && can_read) begin
                        n_fill = fill_m1;
                    end
                    n_state           = ST_IDLE;
                    n_out_valid       = 1'b1;
                    n_rsp.read_byte   = (is_read && ok) ? ram_rdata : '0;
                    n_rsp.success     = ok;
                    n_rsp.is_empty    = (n_fill == '0);
                    n_rsp.is_full     = (n_fill == FILL_W'(DEPTH));
                    n_rsp.entry_count = count_ext[lstk_pkg::COUNT_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign count_ext = {{lstk_pkg::COUNT_W{1'b0}}, n_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req.data;
        end
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("fill level above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_fill == $past(r_fill) + FILL_W'(1)))
        else $error("push did not advance fill level");

    a_rsp_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.data.is_empty == (r_fill == '0)) &&
                         (o_rsp.data.is_full == (r_fill == FILL_W'(DEPTH)))))
        else $error("response status disagrees with fill level");

    a_read_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_state == ST_IDLE) && (r_fill != '0))
        else $error("RAM read issued outside idle or on empty stack");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for lifo_stack: directed table, random bursts, shadow stack check.
`timescale 1ns / 100ps

module testbench;

    localparam int STACK_DEPTH = lstk_pkg::DEPTH_DEF;
    localparam int RANDOM_OPS  = 1250;
    localparam int DIR_N       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;

    localparam logic [lstk_pkg::OP_W-1:0] OP_NOOP = 2'd3;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_NOISE
    } t_mix;

    typedef struct packed {
        logic [lstk_pkg::OP_W-1:0]   op;
        logic [lstk_pkg::DATA_W-1:0] wbyte;
        logic                        typed;
        lstk_pkg::t_rsp              exp;
    } t_op_row;

    localparam t_op_row DIR_TBL [0:DIR_N-1] = '{
        '{lstk_pkg::OP_POP,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd0}},
        '{lstk_pkg::OP_PEEK, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd0}},
        '{OP_NOOP,           8'hA5, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd0}},
        '{lstk_pkg::OP_PUSH, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 7'd1}},
        '{lstk_pkg::OP_PUSH, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 7'd2}},
        '{lstk_pkg::OP_PEEK, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 7'd2}},
        '{lstk_pkg::OP_POP,  8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 7'd1}},
        '{lstk_pkg::OP_POP,  8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 7'd0}},
        '{lstk_pkg::OP_POP,  8'h5A, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd0}},
        '{lstk_pkg::OP_PUSH, 8'h80, 1'b0, '0},
        '{lstk_pkg::OP_PUSH, 8'h01, 1'b0, '0},
        '{lstk_pkg::OP_PUSH, 8'h7F, 1'b0, '0},
        '{OP_NOOP,           8'hFF, 1'b0, '0},
        '{lstk_pkg::OP_PEEK, 8'h3C, 1'b0, '0},
        '{lstk_pkg::OP_POP,  8'h00, 1'b0, '0},
        '{lstk_pkg::OP_POP,  8'h00, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    lstk_req_if req_ch ();
    lstk_rsp_if rsp_ch ();

    lifo_stack #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    logic [lstk_pkg::DATA_W-1:0] shadow_mem [STACK_DEPTH];
    int unsigned                 shadow_level;

    t_op_row        op_seq [$];
    lstk_pkg::t_rsp pending_rsp [$];
    int unsigned    send_idx;
    int unsigned    rx_count;
    int unsigned    mismatches;
    int unsigned    cycles;
    int unsigned    tx_gap;
    int unsigned    rx_gap;
    int unsigned    hold_left;
    bit             quiet;
    bit             all_sent;

    function automatic lstk_pkg::t_rsp apply_stack_op(logic [lstk_pkg::OP_W-1:0] op,
                                                      logic [lstk_pkg::DATA_W-1:0] wbyte);
        lstk_pkg::t_rsp r;
        r = '0;
        case (op)
            lstk_pkg::OP_PUSH: begin
                if (shadow_level < STACK_DEPTH) begin
                    shadow_mem[shadow_level] = wbyte;
                    shadow_level++;
                    r.success = 1'b1;
                end
            end
            lstk_pkg::OP_POP, lstk_pkg::OP_PEEK: begin
                if (shadow_level > 0) begin
                    r.read_byte = shadow_mem[shadow_level-1];
                    if (op == lstk_pkg::OP_POP) begin
                        shadow_level--;
                    end
                    r.success = 1'b1;
                end
            end
            default: ;
        endcase
        r.is_empty    = (shadow_level == 0);
        r.is_full     = (shadow_level == STACK_DEPTH);
        r.entry_count = lstk_pkg::COUNT_W'(shadow_level);
        return r;
    endfunction

    function automatic logic [lstk_pkg::OP_W-1:0] pick_op(t_mix mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                return (r < 85) ? lstk_pkg::OP_PUSH :
                       (r < 95) ? lstk_pkg::OP_PEEK : lstk_pkg::OP_POP;
            end
            MIX_DRAIN: begin
                return (r < 80) ? lstk_pkg::OP_POP :
                       (r < 95) ? lstk_pkg::OP_PEEK : lstk_pkg::OP_PUSH;
            end
            MIX_BALANCED: begin
                return (r < 40) ? lstk_pkg::OP_PUSH : (r < 75) ? lstk_pkg::OP_POP :
                       (r < 95) ? lstk_pkg::OP_PEEK : OP_NOOP;
            end
            default: begin
                return (r < 30) ? lstk_pkg::OP_PUSH : (r < 50) ? lstk_pkg::OP_POP :
                       (r < 90) ? lstk_pkg::OP_PEEK : OP_NOOP;
            end
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        lstk_pkg::t_rsp exp;
        t_op_row        cur;
        bit             issue;
        if (i_rst_n) begin
            issue = !req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                cur = op_seq[send_idx];
                exp = apply_stack_op(cur.op, cur.wbyte);
                if (cur.typed) begin
                    exp = cur.exp;
                end
                pending_rsp.push_back(exp);
                send_idx++;
                if (send_idx % 64 == 0) begin
                    quiet = ($urandom_range(0, 3) == 0);
                end
                issue = 1'b1;
            end
            if (hold_left != 0) begin
                tx_gap = 0;
            end
            if (issue) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    req_ch.valid <= 1'b0;
                end else if (send_idx < op_seq.size()) begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= '{opcode: op_seq[send_idx].op,
                                      push_byte: op_seq[send_idx].wbyte};
                    tx_gap = pick_gap();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
            all_sent = (send_idx == op_seq.size());
        end
    end

    always @(posedge i_clk) begin
        lstk_pkg::t_rsp exp;
        bit             rdy;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected response: expected none, actual %h",
                             $time, rsp_ch.data);
                    mismatches++;
                end else begin
                    exp = pending_rsp.pop_front();
                    cmp_field("read_byte", exp.read_byte, rsp_ch.data.read_byte);
                    cmp_field("success", exp.success, rsp_ch.data.success);
                    cmp_field("is_empty", exp.is_empty, rsp_ch.data.is_empty);
                    cmp_field("is_full", exp.is_full, rsp_ch.data.is_full);
                    cmp_field("entry_count", exp.entry_count, rsp_ch.data.entry_count);
                end
                rx_count++;
                if (rx_count == 200 || rx_count == 700) begin
                    hold_left = HOLD_CYCLES;
                end
                rx_gap = pick_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (all_sent && pending_rsp.size() == 0) begin
                rdy = 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rdy = 1'b0;
            end else begin
                rdy = quiet || ($urandom_range(0, 9) != 0);
            end
            rsp_ch.ready <= rdy;
        end
    end

    initial begin
        t_op_row row;
        t_mix    mix;
        int      len;
        bit      first;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        shadow_level = 0;
        send_idx     = 0;
        rx_count     = 0;
        mismatches   = 0;
        cycles       = 0;
        tx_gap       = 0;
        rx_gap       = 0;
        hold_left    = 0;
        quiet        = 1'b0;
        all_sent     = 1'b0;

        foreach (DIR_TBL[i]) begin
            op_seq.push_back(DIR_TBL[i]);
        end
        first = 1'b1;
        while (op_seq.size() < DIR_N + RANDOM_OPS) begin
            mix   = first ? MIX_FILL : t_mix'($urandom_range(0, 3));
            len   = first ? 100 : $urandom_range(8, 90);
            first = 1'b0;
            repeat (len) begin
                row       = '0;
                row.op    = pick_op(mix);
                row.wbyte = lstk_pkg::DATA_W'($urandom_range(0, 255));
                op_seq.push_back(row);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(all_sent && pending_rsp.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lstk_pkg.sv
hw/rtl/lstk_if.sv
hw/rtl/lstk_ram.sv
hw/rtl/lifo_stack.sv
tb/testbench.sv
